// ===== rtl/ptr_pkg.sv =====
// Shared types and constants for the permutation table reorder block.
// No dependencies; used by ptr_ram and permutation_table_reorder.
`timescale 1ns / 1ps

package ptr_pkg;

  localparam int DEF_ENTRIES = 256;
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 8;
  localparam int VAL_W       = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOOKUP = 3'd0,
    FN_MOVE   = 3'd1,
    FN_SWAP   = 3'd2,
    FN_ROTATE = 3'd3,
    FN_RESET  = 3'd4
  } func_t;

endpackage

// ===== rtl/ptr_ram.sv =====
// Single write port, single read port RAM with registered read data.
// Holds both permutation tables; depends on ptr_pkg for its default depth.
`timescale 1ns / 1ps

module ptr_ram #(
  parameter int DEPTH = 2 * ptr_pkg::DEF_ENTRIES,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/permutation_table_reorder.sv =====
// Top level: two permutation tables in one RAM, walked by a small sequencer.
// Depends on ptr_pkg and ptr_ram.
//
//  channel  | signals                                            | transfer
//  ---------+----------------------------------------------------+-------------------------
//  command  | start, func, table_sel, first_pos, second_pos,     | start high while busy low
//           | amount; busy                                       |
//  result   | done, entry_value, status                          | done high for one cycle
//
// One RAM port pair does all table work, one entry per cycle. Rotate first
// takes ENTRIES off amount until it is below ENTRIES; a command that fails a
// position check, an unknown func or a move onto its own position strobes
// straight from idle. After rst, busy stays high while both tables are filled
// with the identity map. The receiver cannot stall the result.
`timescale 1ns / 1ps

module permutation_table_reorder #(
  parameter int ENTRIES = ptr_pkg::DEF_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ptr_pkg::FUNC_W-1:0]  func,
  input  logic                        table_sel,
  input  logic [ptr_pkg::POS_W-1:0]   first_pos,
  input  logic [ptr_pkg::POS_W-1:0]   second_pos,
  input  logic [ptr_pkg::POS_W-1:0]   amount,
  output logic                        done,
  output logic [ptr_pkg::VAL_W-1:0]   entry_value,
  output logic                        status
);

  localparam int IW   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int CW   = (CNTW > ptr_pkg::POS_W + 1) ? CNTW : ptr_pkg::POS_W + 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_LOOK_RD = 11'b000_0000_0010,
    S_LOOK    = 11'b000_0000_0100,
    S_MOVE    = 11'b000_0000_1000,
    S_PUT     = 11'b000_0001_0000,
    S_REDUCE  = 11'b000_0010_0000,
    S_ROT     = 11'b000_0100_0000,
    S_SW1     = 11'b000_1000_0000,
    S_SW2     = 11'b001_0000_0000,
    S_SW3     = 11'b010_0000_0000,
    S_FILL    = 11'b100_0000_0000
  } state_t;

  state_t                      state;
  logic                        tsel;
  logic                        init;
  logic                        up;
  logic [IW-1:0]               pos1;
  logic [IW-1:0]               pos2;
  logic [ptr_pkg::POS_W-1:0]   amt;
  logic [IW-1:0]               held;
  logic [IW-1:0]               rd_addr;
  logic [CNTW-1:0]             rd_cnt;
  logic                        r_vld;
  logic                        r_first;
  logic [IW-1:0]               r_addr;

  logic                        mem_we;
  logic                        mem_re;
  logic [IW-1:0]               waddr;
  logic [IW-1:0]               raddr;
  logic [IW-1:0]               wdata;
  logic [IW-1:0]               rdata;

  logic                        p1_ok;
  logic                        p2_ok;
  logic [ptr_pkg::POS_W-1:0]   pos_diff;
  logic [CW-1:0]               rot_sum;
  logic [CW-1:0]               rot_mod;

  assign busy  = (state != S_IDLE);
  assign p1_ok = CW'(first_pos) < CW'(ENTRIES);
  assign p2_ok = CW'(second_pos) < CW'(ENTRIES);
  assign pos_diff = (second_pos > first_pos) ? (second_pos - first_pos)
                                             : (first_pos - second_pos);

  assign rot_sum = CW'(rdata) + CW'(amt);
  assign rot_mod = (rot_sum >= CW'(ENTRIES)) ? (rot_sum - CW'(ENTRIES)) : rot_sum;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = r_addr;
    raddr  = rd_addr;
    wdata  = rdata;
    unique case (state)
      S_LOOK_RD: begin
        mem_re = 1'b1;
        raddr  = pos1;
      end
      S_MOVE: begin
        mem_re = (rd_cnt != '0);
        mem_we = r_vld && !r_first;
        waddr  = up ? (r_addr - IW'(1)) : (r_addr + IW'(1));
      end
      S_PUT: begin
        mem_we = 1'b1;
        waddr  = pos2;
        wdata  = held;
      end
      S_ROT: begin
        mem_re = (rd_cnt != '0);
        mem_we = r_vld;
        wdata  = IW'(rot_mod);
      end
      S_SW1: begin
        mem_re = 1'b1;
        raddr  = pos1;
      end
      S_SW2: begin
        mem_re = 1'b1;
        raddr  = pos2;
      end
      S_SW3: begin
        mem_we = 1'b1;
        waddr  = pos1;
      end
      S_FILL: begin
        mem_we = 1'b1;
        waddr  = rd_addr;
        wdata  = rd_addr;
      end
      default: ;
    endcase
  end

  ptr_ram #(
    .DEPTH (2 * ENTRIES),
    .WIDTH (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({tsel, waddr}),
    .wdata (wdata),
    .re    (mem_re),
    .raddr ({tsel, raddr}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      tsel    <= 1'b0;
      init    <= 1'b1;
      rd_addr <= '0;
      r_vld   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          r_vld <= 1'b0;
          if (start) begin
            tsel    <= table_sel;
            pos1    <= IW'(first_pos);
            pos2    <= IW'(second_pos);
            amt     <= amount;
            up      <= (second_pos > first_pos);
            rd_addr <= IW'(first_pos);
            rd_cnt  <= CNTW'({1'b0, pos_diff} + 9'd1);
            entry_value <= '0;
            status      <= 1'b0;
            case (func)
              ptr_pkg::FN_LOOKUP: begin
                if (p1_ok) begin
                  state <= S_LOOK_RD;
                end else begin
                  done <= 1'b1;
                end
              end
              ptr_pkg::FN_MOVE: begin
                if (!(p1_ok && p2_ok)) begin
                  done <= 1'b1;
                end else if (first_pos == second_pos) begin
                  done   <= 1'b1;
                  status <= 1'b1;
                end else begin
                  state <= S_MOVE;
                end
              end
              ptr_pkg::FN_SWAP: begin
                if (p1_ok && p2_ok) begin
                  state <= S_SW1;
                end else begin
                  done <= 1'b1;
                end
              end
              ptr_pkg::FN_ROTATE: begin
                state <= S_REDUCE;
              end
              ptr_pkg::FN_RESET: begin
                rd_addr <= '0;
                state   <= S_FILL;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_LOOK_RD: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          entry_value <= ptr_pkg::VAL_W'(rdata);
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_MOVE: begin
          if (rd_cnt != '0) begin
            rd_addr <= up ? (rd_addr + IW'(1)) : (rd_addr - IW'(1));
            rd_cnt  <= rd_cnt - CNTW'(1);
          end
          r_vld   <= (rd_cnt != '0);
          r_addr  <= rd_addr;
          r_first <= (rd_addr == pos1);
          if (r_vld && r_first) begin
            held <= rdata;
          end
          if (rd_cnt == '0 && r_vld) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_REDUCE: begin
          if (CW'(amt) >= CW'(ENTRIES)) begin
            amt <= amt - ptr_pkg::POS_W'(ENTRIES);
          end else begin
            rd_addr <= '0;
            rd_cnt  <= CNTW'(ENTRIES);
            state   <= S_ROT;
          end
        end
        S_ROT: begin
          if (rd_cnt != '0) begin
            rd_addr <= rd_addr + IW'(1);
            rd_cnt  <= rd_cnt - CNTW'(1);
          end
          r_vld  <= (rd_cnt != '0);
          r_addr <= rd_addr;
          if (rd_cnt == '0 && r_vld) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SW1: begin
          state <= S_SW2;
        end
        S_SW2: begin
          held  <= rdata;
          state <= S_SW3;
        end
        S_SW3: begin
          state <= S_PUT;
        end
        S_FILL: begin
          if (rd_addr == IW'(ENTRIES - 1)) begin
            rd_addr <= '0;
            if (init) begin
              if (!tsel) begin
                tsel <= 1'b1;
              end else begin
                init  <= 1'b0;
                state <= S_IDLE;
              end
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            rd_addr <= rd_addr + IW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for permutation_table_reorder: command driver, result monitor
// and a cycle-free mirror of both permutation tables. Depends on ptr_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import ptr_pkg::*;

  localparam int TBL_ENTRIES   = DEF_ENTRIES;
  localparam int POS_MAX       = TBL_ENTRIES - 1;
  localparam int VAL_MAX       = (1 << VAL_W) - 1;
  localparam int FUNC_SPARE_LO = int'(FN_RESET) + 1;
  localparam int FUNC_SPARE_HI = (1 << FUNC_W) - 1;
  localparam bit TBL_A         = 1'b0;
  localparam bit TBL_B         = 1'b1;
  localparam int RANDOM_CMDS   = 800;
  localparam int SETTLE_CYCLES = 400;
  localparam int MAX_REPORTS   = 20;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              table_sel;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  second_pos;
    logic [POS_W-1:0]  amount;
    int                gap;
    bit                drain;
  } reorder_cmd_t;

  typedef struct packed {
    reorder_cmd_t     cmd;
    logic [VAL_W-1:0] entry_value;
    logic             status;
  } reorder_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [FUNC_W-1:0] func = '0;
  logic             table_sel = 1'b0;
  logic [POS_W-1:0] first_pos = '0;
  logic [POS_W-1:0] second_pos = '0;
  logic [POS_W-1:0] amount = '0;
  logic             busy;
  logic             done;
  logic [VAL_W-1:0] entry_value;
  logic             status;

  permutation_table_reorder #(
    .ENTRIES(TBL_ENTRIES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .table_sel(table_sel),
    .first_pos(first_pos),
    .second_pos(second_pos),
    .amount(amount),
    .done(done),
    .entry_value(entry_value),
    .status(status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  reorder_cmd_t    cmd_queue[$];
  reorder_result_t pending_results[$];
  logic [VAL_W-1:0] perm_mirror [0:1][0:TBL_ENTRIES-1];
  int total_cmds = 0;
  int useful_cmds = 0;
  int cmds_sent = 0;
  int results_seen = 0;
  int errors = 0;

  task automatic report(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  // Mirror of the tables: applies one command and returns the result it produces.
  function automatic reorder_result_t apply_table_op(reorder_cmd_t c);
    reorder_result_t r;
    logic [VAL_W-1:0] held;
    int t;
    int src;
    int dst;
    int k;
    r.cmd = c;
    r.entry_value = '0;
    r.status = 1'b0;
    t = c.table_sel;
    src = c.first_pos;
    dst = c.second_pos;
    case (c.func)
      FN_LOOKUP: begin
        if (src < TBL_ENTRIES) r.entry_value = perm_mirror[t][src];
      end
      FN_MOVE: begin
        if (src < TBL_ENTRIES && dst < TBL_ENTRIES) begin
          if (src == dst) begin
            r.status = 1'b1;
          end else begin
            held = perm_mirror[t][src];
            if (src < dst) begin
              for (k = src; k < dst; k++) perm_mirror[t][k] = perm_mirror[t][k+1];
            end else begin
              for (k = src; k > dst; k--) perm_mirror[t][k] = perm_mirror[t][k-1];
            end
            perm_mirror[t][dst] = held;
          end
        end
      end
      FN_SWAP: begin
        if (src < TBL_ENTRIES && dst < TBL_ENTRIES) begin
          held = perm_mirror[t][src];
          perm_mirror[t][src] = perm_mirror[t][dst];
          perm_mirror[t][dst] = held;
        end
      end
      FN_ROTATE: begin
        for (k = 0; k < TBL_ENTRIES; k++)
          perm_mirror[t][k] = VAL_W'((int'(perm_mirror[t][k]) + int'(c.amount)) % TBL_ENTRIES);
      end
      FN_RESET: begin
        for (k = 0; k < TBL_ENTRIES; k++) perm_mirror[t][k] = VAL_W'(k);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_cmd(logic [FUNC_W-1:0] f, bit sel, int p1, int p2, int amt, int gap,
                         bit drain);
    reorder_cmd_t c;
    c.func = f;
    c.table_sel = sel;
    c.first_pos = POS_W'(p1);
    c.second_pos = POS_W'(p2);
    c.amount = POS_W'(amt);
    c.gap = gap;
    c.drain = drain;
    cmd_queue.push_back(c);
    total_cmds++;
    if (int'(f) <= int'(FN_RESET)) useful_cmds++;
  endtask

  function automatic int pick_gap(bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 8);
    if (roll < 96) return $urandom_range(9, 80);
    return $urandom_range(81, 300);
  endfunction

  function automatic int near_pos(int anchor);
    if ($urandom_range(0, 9) < 6) return (anchor + $urandom_range(0, 16)) % TBL_ENTRIES;
    return $urandom_range(0, POS_MAX);
  endfunction

  // A few edits to one table, then lookups, mostly around the edited region.
  task automatic add_sequence();
    bit calm;
    bit sel;
    int n_ops;
    int n_reads;
    int roll;
    int anchor;
    int p1;
    int p2;
    int i;
    calm = ($urandom_range(0, 3) == 0);
    sel = $urandom_range(0, 1);
    n_ops = $urandom_range(1, 4);
    n_reads = $urandom_range(2, 6);
    anchor = $urandom_range(0, POS_MAX);
    for (i = 0; i < n_ops; i++) begin
      roll = $urandom_range(0, 99);
      p1 = near_pos(anchor);
      p2 = near_pos(p1);
      if (roll < 45)
        add_cmd(FN_MOVE, sel, p1, p2, $urandom_range(0, VAL_MAX), pick_gap(calm),
                ($urandom_range(0, 99) == 0));
      else if (roll < 75)
        add_cmd(FN_SWAP, sel, p1, p2, $urandom_range(0, VAL_MAX), pick_gap(calm), 1'b0);
      else if (roll < 93)
        add_cmd(FN_ROTATE, sel, p1, p2, $urandom_range(0, VAL_MAX), pick_gap(calm), 1'b0);
      else
        add_cmd(FN_RESET, sel, p1, p2, $urandom_range(0, VAL_MAX), pick_gap(calm), 1'b0);
    end
    for (i = 0; i < n_reads; i++)
      add_cmd(FN_LOOKUP, sel, near_pos(anchor), $urandom_range(0, POS_MAX),
              $urandom_range(0, VAL_MAX), pick_gap(calm), 1'b0);
  endtask

  task automatic add_noise();
    add_cmd(FUNC_W'($urandom_range(0, FUNC_SPARE_HI)), $urandom_range(0, 1),
            $urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX),
            $urandom_range(0, VAL_MAX), pick_gap(1'b0), 1'b0);
  endtask

  // Driver
  reorder_cmd_t cur_cmd;
  reorder_cmd_t acc_cmd;
  logic         acc_valid = 1'b0;
  bit           cur_loaded = 1'b0;
  bit           launched;
  bit           next_start;
  int           gap_left = 0;
  int           sent_now;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      acc_valid <= 1'b0;
      cmds_sent <= 0;
      cur_loaded = 1'b0;
      gap_left = 0;
    end else begin
      launched = start && !busy;
      sent_now = cmds_sent + (launched ? 1 : 0);
      cmds_sent <= sent_now;
      acc_valid <= launched;
      if (launched) begin
        acc_cmd <= {func, table_sel, first_pos, second_pos, amount, 32'd0, 1'b0};
      end
      if (!start || launched) begin
        next_start = 1'b0;
        if (!cur_loaded && cmd_queue.size() > 0) begin
          cur_cmd = cmd_queue.pop_front();
          gap_left = cur_cmd.gap;
          cur_loaded = 1'b1;
        end
        if (cur_loaded) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!cur_cmd.drain || results_seen == sent_now) begin
            func <= cur_cmd.func;
            table_sel <= cur_cmd.table_sel;
            first_pos <= cur_cmd.first_pos;
            second_pos <= cur_cmd.second_pos;
            amount <= cur_cmd.amount;
            next_start = 1'b1;
            cur_loaded = 1'b0;
          end
        end
        start <= next_start;
      end
    end
  end

  // Monitor
  reorder_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < 2; t++)
        for (int k = 0; k < TBL_ENTRIES; k++) perm_mirror[t][k] = VAL_W'(k);
      pending_results.delete();
      results_seen <= 0;
    end else begin
      if (acc_valid) pending_results.push_back(apply_table_op(acc_cmd));
      if (done) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          report("result strobe with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          if (entry_value !== want.entry_value)
            report($sformatf("func %0d tbl %0d pos %0d/%0d amt %0d: entry_value %0d, want %0d",
                             want.cmd.func, want.cmd.table_sel, want.cmd.first_pos,
                             want.cmd.second_pos, want.cmd.amount, entry_value,
                             want.entry_value));
          if (status !== want.status)
            report($sformatf("func %0d tbl %0d pos %0d/%0d: status %0b, want %0b",
                             want.cmd.func, want.cmd.table_sel, want.cmd.first_pos,
                             want.cmd.second_pos, status, want.status));
        end
      end
    end
  end

  // Stimulus and end of run
  int directed_useful;

  initial begin
    add_cmd(FN_LOOKUP, TBL_A, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_B, POS_MAX, POS_MAX, VAL_MAX, 0, 1'b0);
    add_cmd(FN_MOVE, TBL_A, 0, POS_MAX, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_A, POS_MAX, 0, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_A, 0, 0, 0, 3, 1'b0);
    add_cmd(FN_MOVE, TBL_A, POS_MAX, 0, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_A, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_MOVE, TBL_A, 7, 7, 0, 0, 1'b0);
    add_cmd(FN_SWAP, TBL_B, 0, POS_MAX, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_B, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_SWAP, TBL_B, 3, 3, 0, 0, 1'b0);
    add_cmd(FN_ROTATE, TBL_B, 0, 0, VAL_MAX, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_B, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_ROTATE, TBL_A, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_ROTATE, TBL_A, 0, 0, 1, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_A, POS_MAX, 0, 0, 0, 1'b0);
    add_cmd(FN_RESET, TBL_B, 0, 0, 0, 0, 1'b0);
    add_cmd(FN_LOOKUP, TBL_B, 0, 0, 0, 0, 1'b0);
    add_cmd(FUNC_W'(FUNC_SPARE_LO), TBL_A, POS_MAX, POS_MAX, VAL_MAX, 0, 1'b0);
    add_cmd(FUNC_W'(FUNC_SPARE_LO + 1), TBL_B, 0, POS_MAX, 0, 0, 1'b0);
    add_cmd(FUNC_W'(FUNC_SPARE_HI), TBL_B, POS_MAX, 0, VAL_MAX, 0, 1'b0);
    add_cmd(FN_RESET, TBL_A, 0, 0, 0, 0, 1'b0);
    // hold off until the tables are quiet before the random part
    add_cmd(FN_LOOKUP, TBL_A, 128, POS_MAX, VAL_MAX, 0, 1'b1);
    directed_useful = useful_cmds;
    while (useful_cmds < directed_useful + RANDOM_CMDS) begin
      if ($urandom_range(0, 99) < 80) add_sequence();
      else add_noise();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!(cmds_sent == total_cmds && results_seen == total_cmds)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report($sformatf("%0d results never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptr_pkg.sv
rtl/ptr_ram.sv
rtl/permutation_table_reorder.sv
sim/testbench.sv
